FILE: src/can_frame_deframer_top_macros.svh
// ----------------------------------------------------------------------------
// CAN frame deframer assertion macros
// Concurrent check helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_DEFRAMER_TOP_MACROS_SVH
`define CAN_FRAME_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfd assertion failed");

// next-cycle implication
`define CFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfd assertion failed");

`else

`define CFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/cfd_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame deframer package
// Frame constants, byte positions, status codes and the queue item type.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // frame markers and checked values
    localparam logic [7:0] START_BYTE   = 8'h02;
    localparam logic [7:0] END_BYTE     = 8'h03;
    localparam logic [7:0] MSG_TYPE     = 8'h00;
    localparam int         EXT_FLAG_BIT = 6;

    // byte positions within a frame (0 means hunting for start)
    localparam logic [4:0] POS_HUNT     = 5'd0;
    localparam logic [4:0] POS_TYPE     = 5'd1;
    localparam logic [4:0] POS_LENGTH   = 5'd2;
    localparam logic [4:0] POS_FLAGS    = 5'd3;
    localparam logic [4:0] POS_ID_FIRST = 5'd4;
    localparam logic [4:0] POS_ID_LAST  = 5'd7;
    localparam logic [4:0] POS_PL_FIRST = 5'd8;
    localparam logic [4:0] POS_PL_LAST  = 5'd15;
    localparam logic [4:0] POS_CSUM     = 5'd16;
    localparam logic [4:0] POS_END      = 5'd17;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_END  = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;
    localparam logic [1:0] STATUS_BAD_CSUM = 2'd3;

    // classified byte passed from front to back
    typedef struct packed {
        logic [4:0] pos;
        logic [7:0] data;
    } t_cfd_item;

endpackage

FILE: src/cfd_front.sv
// ----------------------------------------------------------------------------
// CAN frame deframer front end
// Accepts stream bytes, hunts for the start marker and tags each frame byte
// with its position before passing it to the queue.
// ----------------------------------------------------------------------------
`include "can_frame_deframer_top_macros.svh"

module cfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_q_full,
    output logic               o_push,
    output cfd_pkg::t_cfd_item o_push_item
);
    import cfd_pkg::*;

    logic [4:0] r_pos;
    logic [4:0] n_pos;
    logic       w_accept;
    logic       w_hunting;

    // handshake: take a request whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_hunting  = (r_pos == POS_HUNT) || (r_pos > POS_END);

    // frame bytes go to the queue, hunted bytes are dropped
    assign o_push           = w_accept && !w_hunting;
    assign o_push_item.pos  = r_pos;
    assign o_push_item.data = i_rx_byte;

    // position tracker
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (w_hunting) begin
                n_pos = (i_rx_byte == START_BYTE) ? POS_TYPE : POS_HUNT;
            end else if (r_pos == POS_END) begin
                n_pos = POS_HUNT;
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    `CFD_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_END)
    `CFD_ASSERT_NXT(a_start_enters, i_clk, i_rst_n,
        w_accept && (r_pos == POS_HUNT) && (i_rx_byte == START_BYTE), r_pos == POS_TYPE)

endmodule

FILE: src/cfd_queue.sv
// ----------------------------------------------------------------------------
// CAN frame deframer queue
// Small register FIFO between front and back, so each side stalls alone.
// ----------------------------------------------------------------------------
`include "can_frame_deframer_top_macros.svh"

module cfd_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cfd_pkg::t_cfd_item i_push_item,
    output logic               o_full,
    output logic               o_valid,
    output cfd_pkg::t_cfd_item o_item,
    input  logic               i_pop
);
    import cfd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(QUEUE_DEPTH);

    t_cfd_item        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CFD_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_DEPTH)
    `CFD_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, w_push && w_pop,
        r_count == $past(r_count))

endmodule

FILE: src/cfd_back.sv
// ----------------------------------------------------------------------------
// CAN frame deframer back end
// Collects tagged frame bytes, keeps the running checksum and, on the byte in
// the end position, checks the frame and loads the result register.
// ----------------------------------------------------------------------------
`include "can_frame_deframer_top_macros.svh"

module cfd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  cfd_pkg::t_cfd_item i_item,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_can_id,
    output logic [7:0]         o_data_length,
    output logic               o_extended,
    output logic [63:0]        o_payload
);
    import cfd_pkg::*;

    logic [7:0]  r_sum;
    logic [7:0]  r_type;
    logic [7:0]  r_length;
    logic [7:0]  r_flags;
    logic [31:0] r_id;
    logic [63:0] r_payload;
    logic [7:0]  r_csum;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_out_id;
    logic [7:0]  r_out_length;
    logic        r_out_ext;
    logic [63:0] r_out_payload;

    logic        w_last;
    logic        w_slot_free;
    logic        w_emit;
    logic [1:0]  w_status;

    // pop a request unless it is an end byte with the result slot taken
    assign w_last      = (i_item.pos == POS_END);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_pop       = i_item_valid && (!w_last || w_slot_free);
    assign w_emit      = o_pop && w_last;

    // frame checks in priority order
    always_comb begin
        if (i_item.data != END_BYTE) begin
            w_status = STATUS_BAD_END;
        end else if (r_type != MSG_TYPE) begin
            w_status = STATUS_BAD_TYPE;
        end else if (r_csum != r_sum) begin
            w_status = STATUS_BAD_CSUM;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // field capture and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_type    <= '0;
            r_length  <= '0;
            r_flags   <= '0;
            r_id      <= '0;
            r_payload <= '0;
            r_csum    <= '0;
        end else if (o_pop) begin
            if (i_item.pos == POS_TYPE) begin
                r_sum <= i_item.data;
            end else if (i_item.pos <= POS_PL_LAST) begin
                r_sum <= r_sum + i_item.data;
            end
            case (i_item.pos) inside
                POS_TYPE:   r_type   <= i_item.data;
                POS_LENGTH: r_length <= i_item.data;
                POS_FLAGS:  r_flags  <= i_item.data;
                [POS_ID_FIRST:POS_ID_LAST]: begin
                    r_id <= {i_item.data, r_id[31:8]};
                end
                [POS_PL_FIRST:POS_PL_LAST]: begin
                    r_payload <= {i_item.data, r_payload[63:8]};
                end
                POS_CSUM:   r_csum   <= i_item.data;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_status      <= w_status;
            r_out_id      <= r_id;
            r_out_length  <= r_length;
            r_out_ext     <= r_flags[EXT_FLAG_BIT];
            r_out_payload <= r_payload;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_can_id      = r_out_id;
    assign o_data_length = r_out_length;
    assign o_extended    = r_out_ext;
    assign o_payload     = r_out_payload;

    `CFD_ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, w_emit, r_out_valid)
    `CFD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        !w_emit)

endmodule

FILE: src/can_frame_deframer_top.sv
// An accepted end byte passes through the queue, then its frame result is loaded into the output register.
// Throughput: one byte per cycle; only a stalled result register backs up the queue.
// Queue depth sets how long the input can run ahead of a stalled output.
// Reset (synchronous, active low) returns to hunting, empties the queue and drops any result.
// ----------------------------------------------------------------------------
// CAN frame deframer top level
// Front end tags frame bytes, queue decouples, back end checks and emits.
// ----------------------------------------------------------------------------
module can_frame_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_can_id,
    output logic [7:0]  o_data_length,
    output logic        o_extended,
    output logic [63:0] o_payload
);
    import cfd_pkg::*;

    logic      w_push;
    t_cfd_item w_push_item;
    logic      w_q_full;
    logic      w_q_valid;
    t_cfd_item w_q_item;
    logic      w_pop;

    // byte classification
    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    // decoupling queue
    cfd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_q_full),
        .o_valid     (w_q_valid),
        .o_item      (w_q_item),
        .i_pop       (w_pop)
    );

    // frame assembly and checks
    cfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_can_id      (o_can_id),
        .o_data_length (o_data_length),
        .o_extended    (o_extended),
        .o_payload     (o_payload)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// CAN frame deframer testbench
// Sends 18-byte frames, with line noise and broken frames mixed in, and
// checks each decoded frame against a cycle-free model of the deframer.
// Both handshakes are throttled at random; the result side is held off once
// for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    import cfd_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int RANDOM_BYTES   = 900;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FRAME_BYTES    = 18;
    localparam int DIRECTED_ROWS  = 10;

    // one decoded frame as seen on the result port
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] can_id;
        logic [7:0]  data_length;
        logic        extended;
        logic [63:0] payload;
    } t_frame_result;

    // contents of one frame on the wire; checksum is derived, then offset
    typedef struct packed {
        logic [7:0]  ftype;
        logic [7:0]  len;
        logic [7:0]  flags;
        logic [31:0] id;
        logic [63:0] payload;
        logic [7:0]  csum_delta;
        logic [7:0]  end_byte;
    } t_frame_fields;

    // directed row: line noise, then a frame, optionally with a known status
    typedef struct packed {
        logic [7:0]    noise_len;
        logic [7:0]    noise_byte;
        t_frame_fields frame;
        logic          typed;
        logic [1:0]    status;
    } t_stim_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [7:0]  i_rx_byte     = 8'h00;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [31:0] o_can_id;
    logic [7:0]  o_data_length;
    logic        o_extended;
    logic [63:0] o_payload;

    // deframer model state
    logic [4:0]  frame_pos     = POS_HUNT;
    logic [7:0]  frame_sum     = 8'h00;
    logic [7:0]  frame_type    = 8'h00;
    logic [7:0]  frame_len     = 8'h00;
    logic [7:0]  frame_flags   = 8'h00;
    logic [31:0] frame_id      = 32'h0;
    logic [63:0] frame_payload = 64'h0;
    logic [7:0]  frame_csum    = 8'h00;

    t_frame_result pending_frames [$];
    t_frame_result typed_result;
    bit            use_typed     = 1'b0;
    t_stim_row     directed_rows [DIRECTED_ROWS];

    // flow control between sender and receiver
    logic        calm          = 1'b0;
    logic        hold_go       = 1'b0;
    logic        hold_done     = 1'b0;
    int unsigned hold_left     = 0;

    int unsigned bytes_sent    = 0;
    int unsigned frames_seen   = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned status_count [4] = '{0, 0, 0, 0};

    can_frame_deframer_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_can_id      (o_can_id),
        .o_data_length (o_data_length),
        .o_extended    (o_extended),
        .o_payload     (o_payload)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // advance the deframer model by one byte; returns 1 when a frame completes
    function automatic bit deframe_byte(input logic [7:0] b, output t_frame_result r);
        r = '0;
        if (frame_pos == POS_HUNT || frame_pos > POS_END) begin
            if (b == START_BYTE) begin
                frame_pos = POS_TYPE;
                frame_sum = 8'h00;
            end else begin
                frame_pos = POS_HUNT;
            end
            return 1'b0;
        end
        if (frame_pos <= POS_PL_LAST) begin
            frame_sum = frame_sum + b;
            if (frame_pos == POS_TYPE) begin
                frame_type = b;
            end else if (frame_pos == POS_LENGTH) begin
                frame_len = b;
            end else if (frame_pos == POS_FLAGS) begin
                frame_flags = b;
            end else if (frame_pos <= POS_ID_LAST) begin
                frame_id = {b, frame_id[31:8]};
            end else begin
                frame_payload = {b, frame_payload[63:8]};
            end
            frame_pos = frame_pos + 5'd1;
            return 1'b0;
        end
        if (frame_pos == POS_CSUM) begin
            frame_csum = b;
            frame_pos  = POS_END;
            return 1'b0;
        end
        // end byte: checks in priority order
        if (b != END_BYTE)
            r.status = STATUS_BAD_END;
        else if (frame_type != MSG_TYPE)
            r.status = STATUS_BAD_TYPE;
        else if (frame_csum != frame_sum)
            r.status = STATUS_BAD_CSUM;
        else
            r.status = STATUS_OK;
        r.can_id      = frame_id;
        r.data_length = frame_len;
        r.extended    = frame_flags[EXT_FLAG_BIT];
        r.payload     = frame_payload;
        frame_pos     = POS_HUNT;
        return 1'b1;
    endfunction

    // offer one byte, with random gaps, until the request is taken
    task automatic send_byte(input logic [7:0] b);
        t_frame_result r;
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        if (deframe_byte(b, r))
            pending_frames.push_back(use_typed ? typed_result : r);
    endtask

    // build a frame with its checksum and send the first nbytes of it
    task automatic send_frame(input t_frame_fields f, input int unsigned nbytes);
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] sum;
        fb[0] = START_BYTE;
        fb[1] = f.ftype;
        fb[2] = f.len;
        fb[3] = f.flags;
        for (int i = 0; i < 4; i++)
            fb[4 + i] = f.id[8*i +: 8];
        for (int i = 0; i < 8; i++)
            fb[8 + i] = f.payload[8*i +: 8];
        sum = 8'h00;
        for (int i = 1; i <= 15; i++)
            sum = sum + fb[i];
        fb[16] = sum + f.csum_delta;
        fb[17] = f.end_byte;
        for (int i = 0; i < nbytes; i++)
            send_byte(fb[i]);
    endtask

    // result side: random stalls, one long hold-off, and a calm stretch
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 10);
        end
    end

    // compare each accepted result with the oldest expected frame
    always @(posedge i_clk) begin
        t_frame_result exp_frame;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            frames_seen++;
            status_count[o_status]++;
            if (pending_frames.size() == 0) begin
                $error("unexpected result: status %0d id %h", o_status, o_can_id);
                mismatches++;
            end else begin
                exp_frame = pending_frames.pop_front();
                if (o_status !== exp_frame.status) begin
                    $error("status: expected %0d, got %0d", exp_frame.status, o_status);
                    mismatches++;
                end
                if (o_can_id !== exp_frame.can_id) begin
                    $error("can_id: expected %h, got %h", exp_frame.can_id, o_can_id);
                    mismatches++;
                end
                if (o_data_length !== exp_frame.data_length) begin
                    $error("data_length: expected %h, got %h",
                           exp_frame.data_length, o_data_length);
                    mismatches++;
                end
                if (o_extended !== exp_frame.extended) begin
                    $error("extended: expected %b, got %b", exp_frame.extended, o_extended);
                    mismatches++;
                end
                if (o_payload !== exp_frame.payload) begin
                    $error("payload: expected %h, got %h", exp_frame.payload, o_payload);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        t_frame_fields f;
        int unsigned   rand_base;
        int unsigned   frame_no;
        int unsigned   nbytes;
        int unsigned   noise_len;

        // noise, frame (type len flags id payload csum_offset end), typed, status
        directed_rows = '{
            // first frame after reset, all fields zero
            '{8'd0, 8'h00, '{8'h00, 8'h00, 8'h00, 32'h0, 64'h0, 8'h00, END_BYTE},
              1'b1, STATUS_OK},
            // all-ones fields after noise
            '{8'd3, 8'hFF, '{8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              8'h00, END_BYTE}, 1'b1, STATUS_OK},
            // every check fails: end marker wins
            '{8'd0, 8'h00, '{8'h01, 8'h08, 8'h00, 32'h1, 64'h1, 8'h01, 8'h00},
              1'b1, STATUS_BAD_END},
            // bad type and bad checksum: type wins
            '{8'd0, 8'h00, '{8'h80, 8'h04, 8'h40, 32'h7FFF_FFFF, 64'h0, 8'h55, END_BYTE},
              1'b1, STATUS_BAD_TYPE},
            // checksum only
            '{8'd0, 8'h00, '{8'h00, 8'h01, 8'h00, 32'h0000_07FF, 64'hAA, 8'h80, END_BYTE},
              1'b1, STATUS_BAD_CSUM},
            // end marker all ones
            '{8'd1, 8'h03, '{8'h00, 8'h00, 8'hBF, 32'h0, 64'h0, 8'h00, 8'hFF},
              1'b1, STATUS_BAD_END},
            // start bytes inside the frame are plain data
            '{8'd2, 8'h03, '{8'h00, 8'h02, 8'h02, 32'h0202_0202, 64'h0202_0202_0202_0202,
              8'h00, END_BYTE}, 1'b1, STATUS_OK},
            '{8'd0, 8'h00, '{8'h00, 8'h08, 8'h40, 32'h89AB_CDEF, 64'h0123_4567_89AB_CDEF,
              8'h00, END_BYTE}, 1'b0, STATUS_OK},
            '{8'd0, 8'h00, '{START_BYTE, 8'h05, 8'hBF, 32'h1234_5678, 64'hFEDC_BA98_7654_3210,
              8'h00, END_BYTE}, 1'b0, STATUS_OK},
            '{8'd1, 8'h00, '{8'hFF, 8'h80, 8'h40, 32'h8000_0000, 64'h8000_0000_0000_0001,
              8'hFF, END_BYTE}, 1'b0, STATUS_OK}
        };

        // synchronous reset
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames
        foreach (directed_rows[k]) begin
            for (int n = 0; n < directed_rows[k].noise_len; n++)
                send_byte(directed_rows[k].noise_byte);
            f = directed_rows[k].frame;
            typed_result.status      = directed_rows[k].status;
            typed_result.can_id      = f.id;
            typed_result.data_length = f.len;
            typed_result.extended    = f.flags[EXT_FLAG_BIT];
            typed_result.payload     = f.payload;
            use_typed = directed_rows[k].typed;
            send_frame(f, FRAME_BYTES);
            use_typed = 1'b0;
        end

        // random frames, noise and truncated frames
        rand_base = bytes_sent;
        frame_no  = 0;
        while (bytes_sent - rand_base < RANDOM_BYTES) begin
            if (frame_no == 8)
                hold_go <= 1'b1;
            if (frame_no == 20) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending_frames.size() != 0);
            end
            if (frame_no == 30)
                calm <= 1'b1;
            if (frame_no == 42)
                calm <= 1'b0;

            if ($urandom_range(99) < 10) begin
                noise_len = $urandom_range(5, 1);
                for (int n = 0; n < noise_len; n++)
                    send_byte(8'($urandom));
            end

            f.ftype      = ($urandom_range(99) < 85) ? MSG_TYPE : 8'($urandom);
            f.len        = ($urandom_range(99) < 80) ? 8'($urandom_range(8)) : 8'($urandom);
            f.flags      = 8'($urandom);
            f.id         = $urandom;
            f.payload    = {$urandom, $urandom};
            f.csum_delta = ($urandom_range(99) < 10) ? 8'($urandom_range(255, 1)) : 8'h00;
            f.end_byte   = ($urandom_range(99) < 90) ? END_BYTE : 8'($urandom);
            nbytes       = ($urandom_range(99) < 5) ? $urandom_range(17, 1) : FRAME_BYTES;
            send_frame(f, nbytes);
            frame_no++;
        end
        i_in_valid <= 1'b0;

        // drain outstanding frames, then allow for the output latency
        do @(posedge i_clk); while (pending_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes; checked %0d frames: %0d ok, %0d bad end, %0d bad type,",
                 bytes_sent, frames_seen, status_count[STATUS_OK],
                 status_count[STATUS_BAD_END], status_count[STATUS_BAD_TYPE]);
        $display("%0d bad checksum; %0d field mismatches", status_count[STATUS_BAD_CSUM],
                 mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
